// ===== hw/rtl/afc_pkg.sv =====
// afc_pkg: shared types, widths and register codes for the box/frustum culling block.
// No dependencies; imported by afc_cell, afc_out_buf and aabb_frustum_cull.
package afc_pkg;

  localparam int unsigned NumPlanes = 6;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned PlaneW    = 4 * CoefW;
  localparam int unsigned ProdW     = CoefW + CoordW;
  localparam int unsigned DShift    = 14;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned CfgIdxW   = 3;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // One slot of the cell chain: box plus running visibility
  typedef struct packed {
    logic valid;
    logic vis;
    box_t box;
  } stage_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } cfg_idx_e;

endpackage

// ===== hw/rtl/afc_cell.sv =====
// afc_cell: one plane of the chain; holds the plane register and tests the passing box.
// Depends on afc_pkg.
module afc_cell import afc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              wr_en_i,
  input  logic [PlaneW-1:0] wr_data_i,
  input  stage_t            in_i,
  output stage_t            out_o
);

  logic [PlaneW-1:0] plane_q;

  logic signed [CoefW-1:0] coef_a, coef_b, coef_c, coef_d;

  coord_t sel_x, sel_y, sel_z;

  logic signed [ProdW-1:0] pa_d, pb_d, pc_d;
  logic signed [ProdW-1:0] pa_q, pb_q, pc_q;
  stage_t                  mid_q;

  logic signed [SumW-1:0] d_ext;
  logic signed [SumW-1:0] sum;
  stage_t                 out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (wr_en_i) begin
      plane_q <= wr_data_i;
    end
  end

  assign coef_a = plane_q[CoefW-1:0];
  assign coef_b = plane_q[2*CoefW-1:CoefW];
  assign coef_c = plane_q[3*CoefW-1:2*CoefW];
  assign coef_d = plane_q[4*CoefW-1:3*CoefW];

  // positive vertex: max corner where the normal component is >= 0
  assign sel_x = coef_a[CoefW-1] ? in_i.box.min_x : in_i.box.max_x;
  assign sel_y = coef_b[CoefW-1] ? in_i.box.min_y : in_i.box.max_y;
  assign sel_z = coef_c[CoefW-1] ? in_i.box.min_z : in_i.box.max_z;

  assign pa_d = coef_a * sel_x;
  assign pb_d = coef_b * sel_y;
  assign pc_d = coef_c * sel_z;

  // stage 1: products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      pa_q  <= '0;
      pb_q  <= '0;
      pc_q  <= '0;
    end else if (en_i) begin
      mid_q <= in_i;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      pc_q  <= pc_d;
    end
  end

  // stage 2: exact sum, sign test
  assign d_ext = {{(SumW-CoefW-DShift){coef_d[CoefW-1]}}, coef_d, {DShift{1'b0}}};
  assign sum   = SumW'(pa_q) + SumW'(pb_q) + SumW'(pc_q) + d_ext;

  always_comb begin
    out_d     = mid_q;
    out_d.vis = mid_q.vis & ~sum[SumW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== hw/rtl/afc_out_buf.sv =====
// afc_out_buf: output register plus skid slot; produces the chain advance enable.
// Depends on afc_pkg.
module afc_out_buf import afc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t last_i,
  output logic   en_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output logic   visible_o
);

  logic out_valid_q, out_valid_d;
  logic out_vis_q, out_vis_d;
  logic skid_valid_q, skid_valid_d;
  logic skid_vis_q, skid_vis_d;
  logic arrive, drain;

  // chain only moves while the skid slot is free
  assign en_o   = ~skid_valid_q;
  assign arrive = en_o & last_i.valid;
  assign drain  = out_valid_q & out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_vis_d    = out_vis_q;
    skid_valid_d = skid_valid_q;
    skid_vis_d   = skid_vis_q;
    if (!out_valid_q || drain) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_vis_d    = skid_vis_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = arrive;
        out_vis_d   = last_i.vis;
      end
    end else if (arrive) begin
      skid_valid_d = 1'b1;
      skid_vis_d   = last_i.vis;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_vis_q  <= out_vis_d;
    skid_vis_q <= skid_vis_d;
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = out_vis_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while output register is empty");

  a_no_arrive_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !arrive)
    else $error("result arrived while skid slot full");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && last_i.valid))
    else $error("skid slot filled without a stalled output");

endmodule

// ===== hw/rtl/aabb_frustum_cull.sv =====
// aabb_frustum_cull: top level; six plane cells in a chain followed by the output buffer.
// Depends on afc_pkg, afc_cell, afc_out_buf.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, min_*_i, max_*_i  | box in
//  out     | out_valid_o/out_ready_i, visible_o       | result out
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i,    | plane write
//          | cfg_data_i                               |
//
// One box per cycle sustained while the output is ready. The path holds 13 register stages:
// two per plane cell (products, then sum and sign) over six cells, plus the output register,
// and every box passes them in that order before its result can transfer.
// Reset clears all plane registers (every box visible) and empties the chain; no clearing
// pass. When the output stalls, one extra result lands in the skid slot, then the whole
// chain holds and in_ready_o drops until the skid slot drains.
module aabb_frustum_cull import afc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // box input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  coord_t            min_x_i,
  input  coord_t            min_y_i,
  input  coord_t            min_z_i,
  input  coord_t            max_x_i,
  input  coord_t            max_y_i,
  input  coord_t            max_z_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              visible_o,
  // plane register writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PlaneW-1:0] cfg_data_i
);

  stage_t               chain [NumPlanes+1];
  logic                 en;
  logic [NumPlanes-1:0] wr_en;

  // writes are always taken; indexes past the far plane are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    wr_en = '0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PLANE_LEFT:   wr_en[0] = 1'b1;
        REG_PLANE_RIGHT:  wr_en[1] = 1'b1;
        REG_PLANE_BOTTOM: wr_en[2] = 1'b1;
        REG_PLANE_TOP:    wr_en[3] = 1'b1;
        REG_PLANE_NEAR:   wr_en[4] = 1'b1;
        REG_PLANE_FAR:    wr_en[5] = 1'b1;
        default:          wr_en    = '0;
      endcase
    end
  end

  // head of the chain: a new box starts out visible
  assign in_ready_o         = en;
  assign chain[0].valid     = in_valid_i;
  assign chain[0].vis       = 1'b1;
  assign chain[0].box.min_x = min_x_i;
  assign chain[0].box.min_y = min_y_i;
  assign chain[0].box.min_z = min_z_i;
  assign chain[0].box.max_x = max_x_i;
  assign chain[0].box.max_y = max_y_i;
  assign chain[0].box.max_z = max_z_i;

  // each cell ANDs its plane test into the running visibility
  for (genvar g = 0; g < NumPlanes; g++) begin : g_cell
    afc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .wr_en_i   (wr_en[g]),
      .wr_data_i (cfg_data_i),
      .in_i      (chain[g]),
      .out_o     (chain[g+1])
    );
  end

  afc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .last_i      (chain[NumPlanes]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .visible_o   (visible_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for aabb_frustum_cull (box against six frustum planes).
// Depends on afc_pkg and the aabb_frustum_cull RTL; a built-in plane predictor checks
// every visibility result in order.
`timescale 1ns / 100ps

module tb_top;
  import afc_pkg::*;

  localparam int LATENCY        = 13;    // input transfer to earliest result transfer
  localparam int HOLD_CYCLES    = 80;    // long output hold-off, longer than the chain
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on any channel
  localparam int PHASE_BOXES    = 200;
  localparam int NUM_PHASES     = 7;
  localparam int PRESSURE_BOXES = 48;
  localparam longint D_SCALE    = 64'sd16384;  // d is an integer, coefficients are Q1.14

  // indexes past the last plane; writes to them must be dropped
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef enum int {FLOW_STEADY, FLOW_RANDOM} flow_e;
  typedef enum int {STYLE_RAW, STYLE_FRUSTUM, STYLE_EXTREME} plane_style_e;

  // DUT ports
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  coord_t             min_x_i     = '0;
  coord_t             min_y_i     = '0;
  coord_t             min_z_i     = '0;
  coord_t             max_x_i     = '0;
  coord_t             max_y_i     = '0;
  coord_t             max_z_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               visible_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [PlaneW-1:0]  cfg_data_i  = '0;

  // bench state
  logic [PlaneW-1:0] plane_regs [NumPlanes];  // shadow of the plane registers
  logic              exp_visible_q [$];       // expected results, oldest first
  flow_e             src_flow  = FLOW_STEADY;
  flow_e             sink_flow = FLOW_STEADY;
  int                sink_hold = 0;           // request for one long output hold-off
  int                error_count   = 0;
  int                boxes_sent    = 0;
  int                results_seen  = 0;
  int                visible_seen  = 0;
  int                plane_writes  = 0;
  int                in_stall_cycles = 0;
  int                idle_cycles   = 0;

  always #2 clk_i = ~clk_i;

  aabb_frustum_cull DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .min_x_i     (min_x_i),
    .min_y_i     (min_y_i),
    .min_z_i     (min_z_i),
    .max_x_i     (max_x_i),
    .max_y_i     (max_y_i),
    .max_z_i     (max_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .visible_o   (visible_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor: p-vertex test of the box against the six shadow planes.
  // Per axis the max corner is used where the coefficient is >= 0 (zero too),
  // else the min corner. Sum is exact: a*x + b*y + c*z + d*2^14, culled if < 0.
  // ---------------------------------------------------------------------------
  function automatic logic box_visible(input box_t b);
    coord_t                   lo [3];
    coord_t                   hi [3];
    logic signed [CoefW-1:0]  coef;
    logic signed [CoefW-1:0]  offs;
    coord_t                   corner;
    longint                   sum;
    lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
    hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
    for (int p = 0; p < NumPlanes; p++) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        coef   = plane_regs[p][CoefW*k +: CoefW];
        corner = (coef >= 0) ? hi[k] : lo[k];
        sum    = sum + longint'(coef) * longint'(corner);
      end
      offs = plane_regs[p][PlaneW-1 -: CoefW];
      sum  = sum + longint'(offs) * D_SCALE;
      if (sum < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [PlaneW-1:0] plane_word(input int a, input int b, input int c,
                                                   input int d);
    return {d[CoefW-1:0], c[CoefW-1:0], b[CoefW-1:0], a[CoefW-1:0]};
  endfunction

  function automatic box_t make_box(input int x0, input int y0, input int z0,
                                    input int x1, input int y1, input int z1);
    box_t b;
    b.min_x = coord_t'(x0); b.min_y = coord_t'(y0); b.min_z = coord_t'(z0);
    b.max_x = coord_t'(x1); b.max_y = coord_t'(y1); b.max_z = coord_t'(z1);
    return b;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int src_gap();
    if (src_flow == FLOW_STEADY || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  // Mostly well-formed boxes (min <= max per axis), some near the origin so that
  // the plane offset matters; a few raw ones that may come out inverted.
  function automatic box_t random_box();
    coord_t lo [3];
    coord_t hi [3];
    coord_t t;
    logic   near_origin;
    logic   raw;
    box_t   b;
    near_origin = ($urandom_range(0, 1) == 0);
    raw         = ($urandom_range(0, 6) == 0);
    for (int k = 0; k < 3; k++) begin
      if (near_origin) begin
        lo[k] = coord_t'(int'($urandom_range(0, 4000)) - 2000);
        hi[k] = coord_t'(int'($urandom_range(0, 4000)) - 2000);
      end else begin
        lo[k] = coord_t'($urandom);
        hi[k] = coord_t'($urandom);
      end
      if (!raw && lo[k] > hi[k]) begin
        t = lo[k]; lo[k] = hi[k]; hi[k] = t;
      end
    end
    b.min_x = lo[0]; b.min_y = lo[1]; b.min_z = lo[2];
    b.max_x = hi[0]; b.max_y = hi[1]; b.max_z = hi[2];
    return b;
  endfunction

  function automatic int extreme_val();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [PlaneW-1:0] random_plane(input plane_style_e style);
    case (style)
      STYLE_RAW:
        return {$urandom, $urandom};
      STYLE_FRUSTUM:
        // offset biased positive so a fair share of boxes survive all six planes
        return plane_word($urandom, $urandom, $urandom,
                          int'($urandom_range(0, 4000)) - 1000);
      default:
        return plane_word(extreme_val(), extreme_val(), extreme_val(), extreme_val());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers. Every task is entered and left on a rising-edge time step.
  // ---------------------------------------------------------------------------

  // One box transfer. Valid is left high on return so back-to-back boxes never
  // see valid lowered and raised in one step.
  task automatic send_box(input box_t b);
    int gap;
    gap = src_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    min_x_i <= b.min_x; min_y_i <= b.min_y; min_z_i <= b.min_z;
    max_x_i <= b.max_x; max_y_i <= b.max_y; max_z_i <= b.max_z;
    do @(posedge clk_i); while (!in_ready_o);
    exp_visible_q.push_back(box_visible(b));
    boxes_sent++;
  endtask

  // Block is idle once every expected result is back; every box gives one.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (exp_visible_q.size() != 0) @(posedge clk_i);
  endtask

  // Plane register write; valid drops only after the last write of a burst.
  task automatic write_plane(input logic [CfgIdxW-1:0] idx, input logic [PlaneW-1:0] data,
                             input logic last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    if (idx < NumPlanes) plane_regs[idx] = data;
    plane_writes++;
  endtask

  task automatic report_mismatch(input string what, input logic got, input logic want);
    $display("ERROR @%0t: %s got %0b expected %0b", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
        out_ready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else if (sink_flow == FLOW_RANDOM && $urandom_range(0, 2) == 0) begin
        n = idle_len();
        out_ready_i <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Checker: each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (visible_o === 1'b1) visible_seen++;
      if (exp_visible_q.size() == 0) begin
        report_mismatch("result with nothing pending, visible", visible_o, 1'bx);
      end else if (visible_o !== exp_visible_q[0]) begin
        report_mismatch("visible", visible_o, exp_visible_q.pop_front());
      end else begin
        void'(exp_visible_q.pop_front());
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_ready_o) in_stall_cycles++;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR @%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Planes all zero after reset: every sum is zero, so every box survives,
  // extreme and inverted boxes included.
  task automatic test_reset_planes();
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    send_box(make_box(-32768, 0, 32767, 32767, -1, -32768));
    drain_results();
  endtask

  // Plane edge cases, one plane live at a time.
  task automatic test_plane_edges();
    // x >= 5: exactly zero at the max corner still counts as visible
    write_plane(REG_PLANE_LEFT, plane_word(16384, 0, 0, -5), 1'b1);
    send_box(make_box(-100, -32768, -32768, 5, 32767, 32767));
    send_box(make_box(-100, -32768, -32768, 4, 32767, 32767));
    drain_results();
    write_plane(REG_PLANE_LEFT, '0, 1'b1);

    // negative coefficient selects the min corner: -x + 10 >= 0
    write_plane(REG_PLANE_RIGHT, plane_word(-16384, 0, 0, 10), 1'b1);
    send_box(make_box(10, 0, 0, 32767, 0, 0));
    send_box(make_box(11, 0, 0, 11, 0, 0));
    drain_results();
    write_plane(REG_PLANE_RIGHT, '0, 1'b1);

    // degenerate plane with negative offset culls everything
    write_plane(REG_PLANE_BOTTOM, plane_word(0, 0, 0, -1), 1'b1);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    drain_results();
    write_plane(REG_PLANE_BOTTOM, '0, 1'b1);

    // most negative coefficients, largest offset; then most positive, smallest offset
    write_plane(REG_PLANE_TOP, plane_word(-32768, -32768, -32768, 32767), 1'b1);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    drain_results();
    write_plane(REG_PLANE_TOP, '0, 1'b0);
    write_plane(REG_PLANE_NEAR, plane_word(32767, 32767, 32767, -32768), 1'b1);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, 0, 0, 0));
    drain_results();
    write_plane(REG_PLANE_NEAR, '0, 1'b0);
    write_plane(REG_PLANE_FAR, plane_word(0, -32768, 32767, 0), 1'b1);
    send_box(make_box(0, -32768, 32767, 0, -32768, 32767));
    drain_results();
    write_plane(REG_PLANE_FAR, '0, 1'b1);

    // indexes past the last plane are dropped; an all-ones plane would not cull this box
    write_plane(CFG_IDX_SPARE_LO, '1, 1'b0);
    write_plane(CFG_IDX_SPARE_HI, '1, 1'b1);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    drain_results();
  endtask

  // Random plane sets, one per phase, with random boxes and random idling.
  task automatic test_random_frustums();
    plane_style_e style;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      style = plane_style_e'(ph % 3);
      for (int p = 0; p < NumPlanes; p++) begin
        write_plane(cfg_idx_e'(p), random_plane(style), 1'b0);
      end
      write_plane(CfgIdxW'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                  {$urandom, $urandom}, 1'b1);
      // keep one phase fully back-to-back on both sides
      src_flow  = (ph == 1) ? FLOW_STEADY : flow_e'($urandom_range(0, 1));
      sink_flow = (ph == 1) ? FLOW_STEADY : flow_e'($urandom_range(0, 1));
      for (int i = 0; i < PHASE_BOXES; i++) send_box(random_box());
      drain_results();
    end
  endtask

  // Output held off long enough to fill the chain and stall the input.
  task automatic test_backpressure();
    for (int p = 0; p < NumPlanes; p++) begin
      write_plane(cfg_idx_e'(p), random_plane(STYLE_FRUSTUM), p == NumPlanes - 1);
    end
    src_flow  = FLOW_STEADY;
    sink_flow = FLOW_STEADY;
    sink_hold = HOLD_CYCLES;
    for (int i = 0; i < PRESSURE_BOXES; i++) send_box(random_box());
    drain_results();
  endtask

  initial begin
    for (int p = 0; p < NumPlanes; p++) plane_regs[p] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_planes();
    test_plane_edges();
    test_random_frustums();
    test_backpressure();

    drain_results();
    repeat (LATENCY + 4) @(posedge clk_i);

    $display("Checked %0d box results (%0d visible) over %0d plane writes,",
             results_seen, visible_seen, plane_writes);
    $display("with %0d input stall cycles from output hold-off.", in_stall_cycles);
    if (error_count == 0 && exp_visible_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
